[rtl/threshold_3x3_automaton_step_macros.svh]
// Assertion macros for the 3x3 threshold automaton block.
// Each check expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef THRESHOLD_3X3_AUTOMATON_STEP_MACROS_SVH
`define THRESHOLD_3X3_AUTOMATON_STEP_MACROS_SVH

`ifndef SYNTHESIS
`define T3AS_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define T3AS_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define T3AS_ASSERT_IMPL(label, clock, reset, ante, cons)
`define T3AS_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

[rtl/t3as_pkg.sv]
// Shared constants, types and helpers for the 3x3 threshold automaton block.
// No dependencies; used by the column cells, the window and the top level.
package t3as_pkg;

  localparam int GRID_MAX = 32;
  localparam int COL_W    = $clog2(GRID_MAX);
  localparam int SIZE_W   = $clog2(GRID_MAX + 1);
  localparam int CFG_W    = 6;
  localparam int THR_W    = 4;
  localparam int SUM_W    = 4;

  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 6'd20;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd5;

  // Configuration register indexes.
  localparam logic [0:0] REG_GRID_SIZE = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  // Control broadcast from the top level to every column cell.
  typedef struct packed {
    logic advance;  // a beat is accepted this cycle
    logic restart;  // column counter is beyond a shrunken grid, column 0 is in use
    logic wrap;     // the column in use is the last of its row
    logic src;      // incoming source cell
  } ctrl_t;

  function automatic logic [SUM_W-1:0] ones3(input logic [2:0] v);
    ones3 = SUM_W'(v[0]) + SUM_W'(v[1]) + SUM_W'(v[2]);
  endfunction

endpackage

[rtl/t3as_cell.sv]
// One column cell: holds the two stored rows of its column and the column token.
// Depends on t3as_pkg for the control struct.
module t3as_cell (
  input  logic             clk,
  input  logic             rst,
  input  t3as_pkg::ctrl_t  ctrl,
  input  logic             head,
  input  logic             sel_left,
  output logic             sel_out,
  input  logic [1:0]       rd_in,
  output logic [1:0]       rd_out
);

  logic token;
  logic upper;
  logic middle;
  logic sel;

  // A restart forces the first cell to be the one in use whatever the token says.
  assign sel     = ctrl.restart ? head : token;
  assign sel_out = sel;
  assign rd_out  = rd_in | (sel ? {upper, middle} : 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= head;
    end else if (ctrl.advance) begin
      token <= ctrl.wrap ? head : sel_left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && sel) begin
      upper  <= middle;
      middle <= ctrl.src;
    end
  end

endmodule

[rtl/t3as_window.sv]
// Two-column window and nine-cell sum with the threshold compare.
// Depends on t3as_pkg for widths and the three-bit ones count.
module t3as_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [2:0]                   column,
  input  logic [t3as_pkg::THR_W-1:0]   threshold,
  output logic                         live
);

  logic [5:0]                 window;
  logic [t3as_pkg::SUM_W-1:0] sum;

  assign sum  = t3as_pkg::ones3(window[5:3]) + t3as_pkg::ones3(window[2:0])
              + t3as_pkg::ones3(column);
  assign live = sum > threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (advance) begin
      window <= {window[2:0], column};
    end
  end

endmodule

[rtl/threshold_3x3_automaton_step.sv]
// Top level of the 3x3 threshold automaton step: counters, column cells, output register.
// Depends on t3as_pkg, t3as_cell, t3as_window and the assertion macro header.
//
// Source cells enter one per beat in raster order and the block takes one beat every
// clock cycle as long as results drain; a result held in the output register by a low
// out_ready stalls the input, border cells included. Each accepted cell at row and
// column two or more yields the interior cell one up and one left in the cycle after
// acceptance. The row stores are a chain of one cell per column with a one-hot
// token marking the column in use; the read path through that chain and the nine-cell
// sum set the clock period. Configuration takes effect on the next beat.
`include "threshold_3x3_automaton_step_macros.svh"

module threshold_3x3_automaton_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [t3as_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cell_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [t3as_pkg::COL_W-1:0]   out_row,
  output logic [t3as_pkg::COL_W-1:0]   out_column,
  output logic                         cell_out
);

  localparam int COL_W  = t3as_pkg::COL_W;
  localparam int SIZE_W = t3as_pkg::SIZE_W;
  localparam int GRID_MAX = t3as_pkg::GRID_MAX;

  logic [t3as_pkg::CFG_W-1:0] grid_size;
  logic [t3as_pkg::THR_W-1:0] threshold;
  logic [COL_W-1:0]           row_count;
  logic [COL_W-1:0]           column_count;

  logic [SIZE_W-1:0]   size_use;
  logic                col_restart;
  logic                row_restart;
  logic [COL_W-1:0]    col_eff;
  logic [COL_W-1:0]    row_eff;
  logic                col_last;
  logic                row_last;
  logic                emit;
  logic                in_accept;
  logic                new_cell;
  logic [2:0]          col_bits;
  t3as_pkg::ctrl_t     ctrl;
  logic [GRID_MAX:0]   sel_chain;
  logic [1:0]          rd_chain [GRID_MAX+1];
  logic [GRID_MAX-1:0] sel_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= t3as_pkg::GRID_SIZE_RESET;
      threshold <= t3as_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        t3as_pkg::REG_GRID_SIZE: grid_size <= cfg_data;
        t3as_pkg::REG_THRESHOLD: threshold <= cfg_data[t3as_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_size < t3as_pkg::CFG_W'(3)) begin
      size_use = SIZE_W'(3);
    end else if (int'(grid_size) > GRID_MAX) begin
      size_use = SIZE_W'(GRID_MAX);
    end else begin
      size_use = SIZE_W'(grid_size);
    end
  end

  // Counters left beyond a grid that has just shrunk start over at zero.
  assign col_restart = SIZE_W'(column_count) >= size_use;
  assign row_restart = SIZE_W'(row_count) >= size_use;
  assign col_eff     = col_restart ? '0 : column_count;
  assign row_eff     = row_restart ? '0 : row_count;
  assign col_last    = (SIZE_W'(col_eff) + SIZE_W'(1)) >= size_use;
  assign row_last    = (SIZE_W'(row_eff) + SIZE_W'(1)) >= size_use;
  assign emit        = (row_eff >= COL_W'(2)) && (col_eff >= COL_W'(2));

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (in_accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_eff + COL_W'(1);
      end else begin
        column_count <= col_eff + COL_W'(1);
        row_count    <= row_eff;
      end
    end
  end

  assign ctrl.advance = in_accept;
  assign ctrl.restart = col_restart;
  assign ctrl.wrap    = col_last;
  assign ctrl.src     = cell_in;

  assign sel_chain[0] = 1'b0;
  assign rd_chain[0]  = 2'b00;

  for (genvar i = 0; i < GRID_MAX; i++) begin : g_cell
    t3as_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .head     (i == 0),
      .sel_left (sel_chain[i]),
      .sel_out  (sel_chain[i+1]),
      .rd_in    (rd_chain[i]),
      .rd_out   (rd_chain[i+1])
    );
  end

  assign sel_vec  = sel_chain[GRID_MAX:1];
  // Column tuple: row r-2 on top, then row r-1, then the incoming cell.
  assign col_bits = {rd_chain[GRID_MAX], cell_in};

  t3as_window u_window (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_accept),
    .column    (col_bits),
    .threshold (threshold),
    .live      (new_cell)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_row    <= row_eff - COL_W'(1);
      out_column <= col_eff - COL_W'(1);
      cell_out   <= new_cell;
    end
  end

  `T3AS_ASSERT_IMPL(a_one_column_selected, clk, rst, 1'b1, $onehot(sel_vec))
  `T3AS_ASSERT_IMPL(a_token_tracks_column, clk, rst, 1'b1, sel_vec[col_eff])
  `T3AS_ASSERT_NEXT(a_border_gives_no_beat, clk, rst, in_accept && !emit && !out_valid, !out_valid)
  `T3AS_ASSERT_IMPL(a_result_is_interior, clk, rst, out_valid, (out_row != '0) && (out_column != '0))

endmodule
